/* rtl/core/weather_frame_checker_decoder_assert.svh */
// Assertion helpers, clocked on the rising edge, off while reset is low.
`ifndef WEATHER_FRAME_CHECKER_DECODER_ASSERT_SVH
`define WEATHER_FRAME_CHECKER_DECODER_ASSERT_SVH

// Same-cycle implication.
`define WFCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfcd assertion failed");

// Next-cycle implication.
`define WFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfcd assertion failed");

`endif

/* rtl/core/wfcd_pkg.sv */
package wfcd_pkg;

  // Frame layout
  localparam int FrameMax   = 21;  // bytes kept per frame
  localparam int BasicLen   = 17;  // shortest valid frame
  localparam int BasicSumEnd = 16; // bytes 0..15 go into the basic sum
  localparam int PresSumEnd  = 20; // bytes 17..19 go into the pressure sum
  localparam int CntW       = $clog2(FrameMax + 1);

  localparam logic [7:0]  SyncByte = 8'h24;
  localparam logic [15:0] UvNone   = 16'hFFFF;

  // Decoupling queue
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgLowerIdx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgUpperIdx = 2'd1;
  localparam logic [15:0] LowerReset = 16'd20;
  localparam logic [15:0] UpperReset = 16'd100;

  typedef enum logic [1:0] {
    KindInvalid  = 2'd0,
    KindBasic    = 2'd1,
    KindPressure = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    NightNone  = 2'd0,
    NightDay   = 2'd1,
    NightNight = 2'd2
  } night_e;

  typedef struct packed {
    kind_e        kind;
    logic [8:0]   wind_dir;
    logic         batt_low;
    logic [10:0]  temperature_code;
    logic [7:0]   humidity;
    logic [8:0]   wind_speed_code;
    logic [7:0]   wind_gust_code;
    logic [15:0]  rain_count;
    logic [15:0]  uv_code;
    logic [23:0]  light_code;
    logic [23:0]  pressure_code;
  } rec_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/core/wfcd_if.sv */
interface wfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface wfcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic [8:0]  wind_dir;
  logic        batt_low;
  logic [10:0] temperature_code;
  logic [7:0]  humidity;
  logic [8:0]  wind_speed_code;
  logic [7:0]  wind_gust_code;
  logic [15:0] rain_count;
  logic [15:0] uv_code;
  logic [23:0] light_code;
  logic [23:0] pressure_code;
  logic [1:0]  night_state;

  modport source (
    output valid, output packet_kind, output wind_dir, output batt_low,
    output temperature_code, output humidity, output wind_speed_code,
    output wind_gust_code, output rain_count, output uv_code, output light_code,
    output pressure_code, output night_state, input ready
  );
  modport sink (
    input valid, input packet_kind, input wind_dir, input batt_low,
    input temperature_code, input humidity, input wind_speed_code,
    input wind_gust_code, input rain_count, input uv_code, input light_code,
    input pressure_code, input night_state, output ready
  );
endinterface

/* rtl/core/wfcd_queue.sv */
`include "weather_frame_checker_decoder_assert.svh"

module wfcd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wfcd_pkg::rec_t   push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output wfcd_pkg::rec_t   pop_data_o
);

  wfcd_pkg::rec_t mem_q [wfcd_pkg::QDepth];

  logic [wfcd_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [wfcd_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [wfcd_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == wfcd_pkg::QCntW'(wfcd_pkg::QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == wfcd_pkg::QPtrW'(wfcd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == wfcd_pkg::QPtrW'(wfcd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `WFCD_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= wfcd_pkg::QCntW'(wfcd_pkg::QDepth))
  `WFCD_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, full_o, !push_i)
  `WFCD_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, empty_o, !pop_i)

endmodule

/* rtl/core/wfcd_front.sv */
module wfcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       packet_byte_i,
  input  logic             last_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output wfcd_pkg::rec_t   rec_o
);

  logic [7:0] bytes_q [wfcd_pkg::FrameMax];
  logic [7:0] view    [wfcd_pkg::FrameMax];

  logic [wfcd_pkg::CntW-1:0] count_q, count_d, count_n;
  logic [7:0] basic_q, basic_d, basic_n;
  logic [7:0] pres_q, pres_d, pres_n;
  logic       accept;
  logic       wr;
  logic       basic_ok;
  logic       pres_ok;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && last_byte_i;
  assign wr      = (count_q < wfcd_pkg::CntW'(wfcd_pkg::FrameMax));

  // frame as it stands with this byte merged in
  always_comb begin
    for (int j = 0; j < wfcd_pkg::FrameMax; j++) begin
      view[j] = (wr && count_q == wfcd_pkg::CntW'(j)) ? packet_byte_i : bytes_q[j];
    end
  end

  always_comb begin
    count_n = count_q;
    basic_n = basic_q;
    pres_n  = pres_q;
    if (wr) begin
      count_n = count_q + 1'b1;
      if (count_q < wfcd_pkg::CntW'(wfcd_pkg::BasicSumEnd)) begin
        basic_n = basic_q + packet_byte_i;
      end else if (count_q >= wfcd_pkg::CntW'(wfcd_pkg::BasicLen) &&
                   count_q < wfcd_pkg::CntW'(wfcd_pkg::PresSumEnd)) begin
        pres_n = pres_q + packet_byte_i;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    basic_d = basic_q;
    pres_d  = pres_q;
    if (accept) begin
      count_d = last_byte_i ? '0 : count_n;
      basic_d = last_byte_i ? '0 : basic_n;
      pres_d  = last_byte_i ? '0 : pres_n;
    end
  end

  assign basic_ok = (count_n >= wfcd_pkg::CntW'(wfcd_pkg::BasicLen)) &&
                    (view[0] == wfcd_pkg::SyncByte) && (basic_n == view[16]);
  assign pres_ok  = (count_n >= wfcd_pkg::CntW'(wfcd_pkg::FrameMax)) &&
                    (pres_n == view[20]);

  always_comb begin
    rec_o = '0;
    if (basic_ok) begin
      rec_o.kind             = pres_ok ? wfcd_pkg::KindPressure : wfcd_pkg::KindBasic;
      rec_o.wind_dir         = {view[3][7], view[2]};
      rec_o.batt_low         = view[3][3];
      rec_o.temperature_code = {view[3][2:0], view[4]};
      rec_o.humidity         = view[5];
      rec_o.wind_speed_code  = {view[3][4], view[6]};
      rec_o.wind_gust_code   = view[7];
      rec_o.rain_count       = {view[8], view[9]};
      rec_o.uv_code          = {view[10], view[11]};
      rec_o.light_code       = {view[12], view[13], view[14]};
      if (pres_ok) begin
        rec_o.pressure_code  = {view[17], view[18], view[19]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      basic_q <= '0;
      pres_q  <= '0;
    end else begin
      count_q <= count_d;
      basic_q <= basic_d;
      pres_q  <= pres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr) begin
      bytes_q[count_q] <= packet_byte_i;
    end
  end

endmodule

/* rtl/core/wfcd_back.sv */
module wfcd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfcd_pkg::cfg_wr_t cfg_i,
  input  logic              q_empty_i,
  input  wfcd_pkg::rec_t    rec_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output wfcd_pkg::rec_t    rec_o,
  output logic [1:0]        night_state_o
);

  logic [15:0] lower_q, upper_q;
  logic        first_q, first_d;
  logic        night_q, night_d;
  logic        valid_q, valid_d;
  wfcd_pkg::rec_t rec_q;
  logic [1:0]  state_q, state_d;
  logic [16:0] thr_sum;
  logic        is_night;
  logic        decide;

  assign pop_o   = !q_empty_i && (!valid_q || ready_i);
  assign thr_sum = {1'b0, lower_q} + {1'b0, upper_q};
  assign decide  = (rec_i.kind != wfcd_pkg::KindInvalid) && (rec_i.uv_code != wfcd_pkg::UvNone);

  always_comb begin
    if (first_q) begin
      is_night = ({rec_i.uv_code, 1'b0} < thr_sum);
    end else if (night_q) begin
      is_night = (rec_i.uv_code < upper_q);
    end else begin
      is_night = (rec_i.uv_code < lower_q);
    end
  end

  always_comb begin
    first_d = first_q;
    night_d = night_q;
    state_d = state_q;
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
      state_d = wfcd_pkg::NightNone;
      if (decide) begin
        first_d = 1'b0;
        night_d = is_night;
        state_d = is_night ? wfcd_pkg::NightNight : wfcd_pkg::NightDay;
      end
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= wfcd_pkg::LowerReset;
      upper_q <= wfcd_pkg::UpperReset;
      first_q <= 1'b1;
      night_q <= 1'b0;
      valid_q <= 1'b0;
      state_q <= wfcd_pkg::NightNone;
    end else begin
      if (cfg_i.en && cfg_i.idx == wfcd_pkg::CfgLowerIdx) begin
        lower_q <= cfg_i.data;
      end
      if (cfg_i.en && cfg_i.idx == wfcd_pkg::CfgUpperIdx) begin
        upper_q <= cfg_i.data;
      end
      first_q <= first_d;
      night_q <= night_d;
      valid_q <= valid_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
  end

  assign valid_o       = valid_q;
  assign rec_o         = rec_q;
  assign night_state_o = state_q;

endmodule

/* rtl/core/weather_frame_checker_decoder.sv */
// Channel   Dir  Payload                                  Moves a request when
// in_i      in   packet_byte, last_byte                   in_i.valid & in_i.ready
// out_o     out  packet_kind .. night_state (12 fields)   out_o.valid & out_o.ready
// cfg       in   cfg_idx_i, cfg_wdata_i                   cfg_we_i
//
// One byte per cycle sustained while the queue is not full; a frame's result is
// written into the queue and then into the output register before it is valid.
// rst_ni clears counters, sums, the queue, the output valid flag and hysteresis
// state; thresholds reset to 20 and 100.
// in_i stalls only when the queue holds two finished frames; the output
// register is refilled in the cycle its request is taken if the queue holds a frame.
module weather_frame_checker_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wfcd_in_if.sink                       in_i,
  wfcd_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [wfcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wfcd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  wfcd_pkg::rec_t    front_rec;
  wfcd_pkg::rec_t    q_rec;
  wfcd_pkg::rec_t    out_rec;
  wfcd_pkg::cfg_wr_t cfg;
  logic [1:0]        night_state;

  assign cfg.en   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  // Front: byte store, running sums, frame classification and field unpack.
  // Decoding is done on the last byte itself so the store can take the next
  // frame's first byte in the following cycle.
  wfcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .packet_byte_i (in_i.packet_byte),
    .last_byte_i   (in_i.last_byte),
    .q_full_i      (q_full),
    .push_o        (push),
    .rec_o         (front_rec)
  );

  // Decouples frame classification from result delivery.
  wfcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_rec),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rec)
  );

  // Back: day/night hysteresis in frame order, thresholds, output register.
  wfcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .rec_i         (q_rec),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .rec_o         (out_rec),
    .night_state_o (night_state)
  );

  assign out_o.packet_kind      = out_rec.kind;
  assign out_o.wind_dir         = out_rec.wind_dir;
  assign out_o.batt_low         = out_rec.batt_low;
  assign out_o.temperature_code = out_rec.temperature_code;
  assign out_o.humidity         = out_rec.humidity;
  assign out_o.wind_speed_code  = out_rec.wind_speed_code;
  assign out_o.wind_gust_code   = out_rec.wind_gust_code;
  assign out_o.rain_count       = out_rec.rain_count;
  assign out_o.uv_code          = out_rec.uv_code;
  assign out_o.light_code       = out_rec.light_code;
  assign out_o.pressure_code    = out_rec.pressure_code;
  assign out_o.night_state      = night_state;

endmodule
